@@ rtl/efla_pkg.sv @@
// Shared types, constants and helpers of the earliest free lane assigner.
`timescale 1ns / 1ps

package efla_pkg;

  localparam int MAX_LANES = 16;
  localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int TREE_LEVELS = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 0;
  localparam int TREE_N = 1 << TREE_LEVELS;

  localparam int TIME_W = 32;
  localparam int SVC_W = 20;
  localparam int FIELD_W = 5;
  localparam int CFG_W = 5;
  localparam int ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 16;

  localparam logic [CFG_W-1:0] NUM_LANES_RESET = CFG_W'(16);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Register index as decoded from the word address bits of paddr.
  localparam logic [ADDR_W-3:0] REG_NUM_LANES = '0;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [LANE_W-1:0] lane_idx_t;
  typedef time_t [MAX_LANES-1:0] lane_times_t;

  typedef struct packed {
    logic [SVC_W-1:0] svc;
    logic             last;
  } job_t;

  typedef struct packed {
    lane_idx_t chosen;
    lane_idx_t next;
  } lane_result_t;

  // Lane number counted from one, cut to the width of the result fields.
  function automatic logic [FIELD_W-1:0] lane_field(input lane_idx_t idx);
    logic [LANE_W:0] num;
    num = {1'b0, idx} + (LANE_W + 1)'(1);
    return FIELD_W'(num);
  endfunction

endpackage

@@ rtl/efla_cfg.sv @@
// APB-style register port holding the lane count.
`timescale 1ns / 1ps

module efla_cfg
  import efla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_W-1:0]      num_lanes
);

  logic sel_num_lanes;

  assign sel_num_lanes = (paddr[ADDR_W-1:2] == REG_NUM_LANES);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_lanes <= NUM_LANES_RESET;
    end else if (psel && penable && pwrite && pready && sel_num_lanes) begin
      num_lanes <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_num_lanes) begin
      prdata = APB_DATA_W'(num_lanes);
    end
  end

endmodule

@@ rtl/efla_min_tree.sv @@
// Comparator tree that finds the active lane with the smallest time.
`timescale 1ns / 1ps

module efla_min_tree
  import efla_pkg::*;
(
  input  lane_times_t      times,
  input  logic [CFG_W-1:0] num_lanes,
  output lane_idx_t        best
);

  typedef struct packed {
    logic      ok;
    lane_idx_t idx;
    time_t     t;
  } node_t;

  node_t node [2*TREE_N-1];

  // Lane one always takes part, so a count of zero acts as one lane.
  for (genvar i = 0; i < TREE_N; i++) begin : g_leaf
    if (i < MAX_LANES) begin : g_real
      assign node[TREE_N-1+i].ok  = (i == 0) || (32'(num_lanes) > 32'(i));
      assign node[TREE_N-1+i].idx = LANE_W'(i);
      assign node[TREE_N-1+i].t   = times[i];
    end else begin : g_pad
      assign node[TREE_N-1+i] = '0;
    end
  end

  // The left child holds the lower lanes, so it wins a tie.
  for (genvar k = 0; k < TREE_N - 1; k++) begin : g_node
    assign node[k] = (node[2*k+1].ok && (!node[2*k+2].ok || node[2*k+1].t <= node[2*k+2].t))
                     ? node[2*k+1] : node[2*k+2];
  end

  assign best = node[0].idx;

endmodule

@@ rtl/efla_lane_bank.sv @@
// Lane time registers, saturating update and the registered earliest lane.
`timescale 1ns / 1ps

module efla_lane_bank
  import efla_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] num_lanes,
  input  logic             fire,
  input  job_t             job,
  output lane_result_t     res
);

  lane_times_t lanes;
  lane_times_t lanes_next;
  lane_idx_t   best;
  lane_idx_t   best_next;
  lane_idx_t   tree_best;
  time_t       sum;
  logic [TIME_W:0] wide_sum;

  assign wide_sum = {1'b0, lanes[best]} + (TIME_W + 1)'(job.svc);
  assign sum = wide_sum[TIME_W] ? TIME_MAX : wide_sum[TIME_W-1:0];

  always_comb begin
    lanes_next = lanes;
    if (fire) begin
      lanes_next[best] = sum;
    end
  end

  // The tree also runs while idle, so best follows a new lane count.
  efla_min_tree u_tree (
    .times     (lanes_next),
    .num_lanes (num_lanes),
    .best      (tree_best)
  );

  assign best_next = (fire && job.last) ? '0 : tree_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes <= '0;
      best  <= '0;
    end else begin
      best <= best_next;
      if (fire && job.last) begin
        lanes <= '0;
      end else begin
        lanes <= lanes_next;
      end
    end
  end

  assign res.chosen = best;
  assign res.next   = tree_best;

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    fire && job.last |=> (lanes == '0) && (best == '0))
    else $error("lane times not cleared after the last job of a batch");

  a_chosen_grows: assert property (@(posedge clk) disable iff (rst)
    fire && !job.last |=> lanes[$past(best)] >= $past(lanes[best]))
    else $error("chosen lane time decreased");

  a_other_lanes_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> lanes == $past(lanes))
    else $error("lane times changed without a job");

endmodule

@@ rtl/earliest_free_lane_assigner.sv @@
// Top level of the earliest free lane assigner.
`timescale 1ns / 1ps

// Each job goes to the active lane with the smallest busy-until time (lower lane on a tie);
// the job's service time is added to that lane, saturating at 2^32-1, and the result item
// gives the lane used, the lane the next job would get unless this one is marked tlast, and a
// copy of tlast. A job marked tlast clears all lane times afterwards. One item is taken every
// clock cycle while the output is not stalled; a job is held in the input register and its
// result in the output register. The cycle time is set by the saturating add into one lane
// followed by the comparator tree over all lane times. Lane times reset to zero at once, with
// no clearing pass. The user must write the lane count only while idle; it is not enforced.
module earliest_free_lane_assigner
  import efla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [19:0] service_time, rest zero
  input  logic                  s_tlast,   // last_job
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [4:0] assigned_lane, [9:5] next_lane, rest zero
  output logic                  m_tlast,   // batch_done
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] num_lanes;
  logic             in_valid;
  job_t             in_job;
  logic             out_take;
  logic             fire;
  lane_result_t     res;

  efla_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .num_lanes (num_lanes)
  );

  assign out_take = !m_tvalid || m_tready;
  assign fire = in_valid && out_take;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_job.svc  <= s_tdata[SVC_W-1:0];
      in_job.last <= s_tlast;
    end
  end

  efla_lane_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .num_lanes (num_lanes),
    .fire      (fire),
    .job       (in_job),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_take) begin
      m_tvalid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= M_TDATA_W'({lane_field(res.next), lane_field(res.chosen)});
      m_tlast <= in_job.last;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("job processed without a result item");

  a_job_waits: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_job))
    else $error("waiting job lost or changed");

  a_no_fire_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result overwritten");

endmodule
